// File: rtl/core/lob_pkg.sv
// shared types and codes for the limit order book matcher
package lob_pkg;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;

  localparam logic [1:0] RK_FILL    = 2'd0;
  localparam logic [1:0] RK_SUMMARY = 2'd1;
  localparam logic [1:0] RK_CANCEL  = 2'd2;

  localparam logic [2:0] OC_RESTED    = 3'd0;
  localparam logic [2:0] OC_FILLED    = 3'd1;
  localparam logic [2:0] OC_MKT_DROP  = 3'd2;
  localparam logic [2:0] OC_FULL_DROP = 3'd3;
  localparam logic [2:0] OC_CANCELLED = 3'd4;
  localparam logic [2:0] OC_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic        side;
    logic        order_kind;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [63:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] buy_id;
    logic [63:0] sell_id;
    logic [31:0] fill_price;
    logic [31:0] fill_qty;
    logic [63:0] order_id;
    logic [31:0] remaining_qty;
    logic [2:0]  outcome;
    logic        last;
  } res_t;

  // one resting order as stored in the slot memory
  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] order_id;
  } slot_t;

endpackage

// File: rtl/core/lob_slot_mem.sv
// slot memory: one write port, one registered read port
module lob_slot_mem #(
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  lob_pkg::slot_t           wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output lob_pkg::slot_t           rdata_o
);
  import lob_pkg::*;

  slot_t mem [Depth];
  slot_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/limit_order_book_matcher.sv
// limit order book matcher: command sequencer around the slot memory
//
//  channel | dir | handshake              | payload
//  command | in  | start & !busy          | req_i  (lob_pkg::req_t)
//  result  | out | res_valid_o, one cycle | res_o  (lob_pkg::res_t)
//
// a cancel reads the slot memory one slot at a time until the id is found, then answers.
// each fill of a submit takes a full scan of the slot memory for the best price and
// oldest id, a decision state and a write-back state.
// a resting remainder adds a search for the lowest free slot.
// reset empties the book at once (valid bits) and sets the next id to one.
// results leave one per cycle at most and are never held off.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lob_pkg::req_t req_i,
  output logic          res_valid_o,
  output lob_pkg::res_t res_o
);
  import lob_pkg::*;

  localparam int IdxW = $clog2(ORDER_SLOTS);
  localparam int CntW = $clog2(ORDER_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ORDER_SLOTS - 1);
  localparam logic [CntW-1:0] MaxFill = CntW'(ORDER_SLOTS);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_LAST   = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_FILL   = 8'b0001_0000,
    ST_FIN    = 8'b0010_0000,
    ST_FREE   = 8'b0100_0000,
    ST_SUMM   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [63:0] next_id_q, next_id_d;
  logic [63:0] oid_q, oid_d;
  logic [31:0] qty_q, qty_d;
  logic [CntW-1:0] nfill_q, nfill_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic            have_q, have_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  slot_t           best_q, best_d;
  logic [2:0]      oc_q, oc_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t           wdata, rdata;

  lob_slot_mem #(.Depth(ORDER_SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // candidate check on the slot read in the previous cycle
  logic opp;
  logic cand, better, id_hit, price_ok;
  logic [31:0] fq, rest_qty;

  always_comb begin
    opp    = ~req_q.side;
    cand   = pv_q && valid_q[pidx_q] && (rdata.side == opp);
    if (rdata.price == best_q.price) begin
      better = rdata.order_id < best_q.order_id;
    end else if (opp == SIDE_SELL) begin
      better = rdata.price < best_q.price;
    end else begin
      better = rdata.price > best_q.price;
    end
    id_hit = pv_q && valid_q[pidx_q] && (rdata.order_id == req_q.cancel_id);
    if (req_q.order_kind == KIND_MARKET) begin
      price_ok = 1'b1;
    end else if (req_q.side == SIDE_BUY) begin
      price_ok = best_q.price <= req_q.price;
    end else begin
      price_ok = best_q.price >= req_q.price;
    end
    fq       = (qty_q < best_q.qty) ? qty_q : best_q.qty;
    rest_qty = best_q.qty - fq;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    valid_d     = valid_q;
    next_id_d   = next_id_q;
    oid_d       = oid_q;
    qty_d       = qty_q;
    nfill_d     = nfill_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    have_d      = have_q;
    bidx_d      = bidx_q;
    best_d      = best_q;
    oc_d        = oc_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    raddr       = cnt_q;
    we          = 1'b0;
    waddr       = bidx_q;
    wdata       = best_q;

    // fold the previous read into the best candidate
    if ((state_q == ST_SCAN || state_q == ST_LAST) && req_q.cmd == CMD_SUBMIT && cand &&
        (!have_q || better)) begin
      have_d = 1'b1;
      bidx_d = pidx_q;
      best_d = rdata;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d  = req_i;
          cnt_d  = '0;
          have_d = 1'b0;
          if (req_i.cmd == CMD_CANCEL) begin
            state_d = ST_SCAN;
          end else begin
            oid_d     = next_id_q;
            next_id_d = next_id_q + 64'd1;
            qty_d     = req_i.quantity;
            nfill_d   = '0;
            state_d   = (req_i.quantity == '0) ? ST_FIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pv_d   = 1'b1;
        pidx_d = cnt_q;
        if (req_q.cmd == CMD_CANCEL && id_hit) begin
          valid_d[pidx_q] = 1'b0;
          oc_d            = OC_CANCELLED;
          state_d         = ST_SUMM;
        end else if (cnt_q == LastIdx) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LAST: begin
        if (req_q.cmd == CMD_CANCEL) begin
          if (id_hit) begin
            valid_d[pidx_q] = 1'b0;
            oc_d            = OC_CANCELLED;
          end else begin
            oc_d = OC_NOT_FOUND;
          end
          state_d = ST_SUMM;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (have_q && price_ok) ? ST_FILL : ST_FIN;
      end
      ST_FILL: begin
        // trade at the resting price and write the slot back
        we          = 1'b1;
        wdata.qty   = rest_qty;
        if (rest_qty == '0) begin
          valid_d[bidx_q] = 1'b0;
        end
        res_valid_d        = 1'b1;
        res_d.result_kind  = RK_FILL;
        res_d.buy_id       = (req_q.side == SIDE_BUY) ? oid_q : best_q.order_id;
        res_d.sell_id      = (req_q.side == SIDE_BUY) ? best_q.order_id : oid_q;
        res_d.fill_price   = best_q.price;
        res_d.fill_qty     = fq;
        qty_d   = qty_q - fq;
        nfill_d = nfill_q + 1'b1;
        cnt_d   = '0;
        have_d  = 1'b0;
        state_d = (qty_d == '0 || nfill_d == MaxFill) ? ST_FIN : ST_SCAN;
      end
      ST_FIN: begin
        cnt_d = '0;
        if (qty_q == '0) begin
          oc_d    = OC_FILLED;
          state_d = ST_SUMM;
        end else if (req_q.order_kind == KIND_MARKET) begin
          oc_d    = OC_MKT_DROP;
          state_d = ST_SUMM;
        end else begin
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        // lowest free slot takes the remainder
        if (!valid_q[cnt_q]) begin
          we              = 1'b1;
          waddr           = cnt_q;
          wdata.side      = req_q.side;
          wdata.price     = req_q.price;
          wdata.qty       = qty_q;
          wdata.order_id  = oid_q;
          valid_d[cnt_q]  = 1'b1;
          oc_d            = OC_RESTED;
          state_d         = ST_SUMM;
        end else if (cnt_q == LastIdx) begin
          oc_d    = OC_FULL_DROP;
          state_d = ST_SUMM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SUMM: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        res_d.outcome = oc_q;
        if (req_q.cmd == CMD_CANCEL) begin
          res_d.result_kind = RK_CANCEL;
          res_d.order_id    = req_q.cancel_id;
        end else begin
          res_d.result_kind   = RK_SUMMARY;
          res_d.order_id      = oid_q;
          res_d.remaining_qty = qty_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      next_id_q   <= 64'd1;
      nfill_q     <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      next_id_q   <= next_id_d;
      nfill_q     <= nfill_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      have_q      <= have_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    oid_q  <= oid_d;
    qty_q  <= qty_d;
    pidx_q <= pidx_d;
    bidx_q <= bidx_d;
    best_q <= best_d;
    oc_q   <= oc_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // a write-back always produces a fill beat
  a_fill_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |=> (res_valid_o && res_o.result_kind == RK_FILL && !res_o.last))
    else $error("fill state without fill beat");

  // the closing beat of a command comes right after the summary state
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUMM) |=> (res_valid_o && res_o.last && !busy))
    else $error("missing closing beat");

  // accepted command makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but not busy");

  // fills per submit bounded by the book size
  a_nfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfill_q <= MaxFill)
    else $error("fill count overflow");

endmodule

// File: tb/tb_limit_order_book_matcher.sv
// testbench for the limit order book matcher: directed table plus random orders and cancels
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;
  import lob_pkg::*;

  localparam int SLOTS = 32;
  localparam int ReqW  = $bits(req_t);

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  limit_order_book_matcher #(.ORDER_SLOTS(SLOTS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // predictor copy of the book
  logic        bk_valid [SLOTS];
  logic        bk_side  [SLOTS];
  logic [31:0] bk_price [SLOTS];
  logic [31:0] bk_qty   [SLOTS];
  logic [63:0] bk_id    [SLOTS];
  logic [63:0] bk_next_id;

  res_t expected_q[$];
  int   n_errors;
  int   n_results;
  int   n_fills;
  int   n_cancel_hits;
  int   n_full;
  logic [63:0] issued_ids[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // limit
  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  function automatic res_t mk_res(logic [1:0] rk, logic [63:0] bid, logic [63:0] sid,
                                  logic [31:0] fp, logic [31:0] fq, logic [63:0] oid,
                                  logic [31:0] rem, logic [2:0] oc, logic lst);
    res_t r;
    r.result_kind = rk; r.buy_id = bid; r.sell_id = sid; r.fill_price = fp;
    r.fill_qty = fq; r.order_id = oid; r.remaining_qty = rem; r.outcome = oc;
    r.last = lst;
    return r;
  endfunction

  // append one expected beat
  function automatic void exp_add(res_t x);
    expected_q.insert(expected_q.size(), x);
  endfunction

  // remember an id handed out to a submit
  function automatic void id_add(logic [63:0] id);
    issued_ids.insert(issued_ids.size(), id);
  endfunction

  // best resting order on one side, -1 when empty
  function automatic int best_resting(logic rest_side);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_valid[i] || bk_side[i] != rest_side) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (bk_price[i] == bk_price[best]) better = bk_id[i] < bk_id[best];
      else if (rest_side == SIDE_SELL) better = bk_price[i] < bk_price[best];
      else better = bk_price[i] > bk_price[best];
      if (better) best = i;
    end
    return best;
  endfunction

  // apply one command to the book, queue the results it causes
  task automatic match_order(input req_t r);
    logic [63:0] oid;
    logic [31:0] qty, fq;
    logic [2:0]  oc;
    int n, b, f;
    n = 0;
    if (r.cmd == CMD_CANCEL) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (bk_valid[i] && bk_id[i] == r.cancel_id) begin
          bk_valid[i] = 1'b0;
          exp_add(mk_res(RK_CANCEL, '0, '0, '0, '0, r.cancel_id, '0, OC_CANCELLED, 1'b1));
          n_cancel_hits++;
          return;
        end
      end
      exp_add(mk_res(RK_CANCEL, '0, '0, '0, '0, r.cancel_id, '0, OC_NOT_FOUND, 1'b1));
      return;
    end
    oid = bk_next_id;
    bk_next_id = bk_next_id + 64'd1;
    id_add(oid);
    qty = r.quantity;
    while (qty != 0 && n < SLOTS) begin
      b = best_resting(~r.side);
      if (b < 0) break;
      if (r.order_kind == KIND_LIMIT) begin
        if (r.side == SIDE_BUY && bk_price[b] > r.price) break;
        if (r.side == SIDE_SELL && bk_price[b] < r.price) break;
      end
      fq = (qty < bk_qty[b]) ? qty : bk_qty[b];
      qty -= fq;
      bk_qty[b] -= fq;
      if (r.side == SIDE_BUY)
        exp_add(mk_res(RK_FILL, oid, bk_id[b], bk_price[b], fq, '0, '0, '0, 1'b0));
      else
        exp_add(mk_res(RK_FILL, bk_id[b], oid, bk_price[b], fq, '0, '0, '0, 1'b0));
      n++;
      n_fills++;
      if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
    end
    if (qty == 0) oc = OC_FILLED;
    else if (r.order_kind == KIND_MARKET) oc = OC_MKT_DROP;
    else begin
      f = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!bk_valid[i]) begin
          f = i;
          break;
        end
      end
      if (f < 0) begin
        oc = OC_FULL_DROP;
        n_full++;
      end else begin
        bk_valid[f] = 1'b1; bk_side[f] = r.side; bk_price[f] = r.price;
        bk_qty[f] = qty; bk_id[f] = oid;
        oc = OC_RESTED;
      end
    end
    exp_add(mk_res(RK_SUMMARY, '0, '0, '0, '0, oid, qty, oc, 1'b1));
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_o !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, res_o);
          n_errors++;
        end
      end
    end
  end

  // send one command beat after an optional random gap; start goes low between beats
  task automatic send_cmd(input req_t r, input bit use_gap);
    int gap;
    gap = use_gap ? $urandom_range(0, 12) : 0;
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    match_order(r);
    start <= 1'b0;
  endtask

  function automatic req_t mk_sub(logic sd, logic kd, logic [31:0] p, logic [31:0] q);
    req_t r;
    r = '0;
    r.cmd = CMD_SUBMIT; r.side = sd; r.order_kind = kd; r.price = p; r.quantity = q;
    r.cancel_id = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t mk_cancel(logic [63:0] id);
    req_t r;
    r = ReqW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.cmd = CMD_CANCEL;
    r.cancel_id = id;
    return r;
  endfunction

  // directed table: command, and a typed summary where it is obvious
  typedef struct {
    req_t        cmd_beat;
    logic        has_exp;
    logic [31:0] exp_rem;
    logic [2:0]  exp_oc;
  } row_t;

  row_t dir_rows[$];

  function automatic row_t mk_row(req_t r, logic h, logic [31:0] rem, logic [2:0] oc);
    row_t x;
    x.cmd_beat = r; x.has_exp = h; x.exp_rem = rem; x.exp_oc = oc;
    return x;
  endfunction

  // append one table row
  function automatic void row_add(row_t x);
    dir_rows.insert(dir_rows.size(), x);
  endfunction

  initial begin
    req_t r;
    int   mode, pick, gap_mode;
    logic [31:0] base;
    n_errors = 0; n_results = 0; n_fills = 0; n_cancel_hits = 0; n_full = 0;
    for (int i = 0; i < SLOTS; i++) begin
      bk_valid[i] = 1'b0; bk_side[i] = 1'b0; bk_price[i] = '0; bk_qty[i] = '0; bk_id[i] = '0;
    end
    bk_next_id = 64'd1;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty book cases, then extremes, zero quantity, crossing, market orders
    row_add(mk_row(mk_cancel(64'd1), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_MARKET, 0, 5), 1'b1, 5, OC_MKT_DROP));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_LIMIT, 100, 0), 1'b1, '0, OC_FILLED));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                   1'b1, 32'hFFFF_FFFF, OC_RESTED));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_LIMIT, 0, 32'hFFFF_FFFF), 1'b1,
                   32'hFFFF_FFFF, OC_RESTED));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_LIMIT, 50, 10), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_LIMIT, 50, 7), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_LIMIT, 40, 3), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_LIMIT, 45, 5), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_LIMIT, 50, 12), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_MARKET, 32'hFFFF_FFFF, 20), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_BUY, KIND_LIMIT, 60, 4), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_MARKET, 0, 2), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_LIMIT, 61, 1), 1'b0, '0, '0));
    row_add(mk_row(mk_cancel(64'd14), 1'b0, '0, '0));
    row_add(mk_row(mk_cancel(64'd14), 1'b0, '0, '0));
    row_add(mk_row(mk_cancel(64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0, '0));
    row_add(mk_row(mk_sub(SIDE_SELL, KIND_MARKET, 5, 0), 1'b1, '0, OC_FILLED));
    // cancel ids 4 and 5; id 4 is the extreme buy order
    row_add(mk_row(mk_cancel(64'd4), 1'b0, '0, '0));
    row_add(mk_row(mk_cancel(64'd5), 1'b0, '0, '0));

    foreach (dir_rows[k]) begin
      send_cmd(dir_rows[k].cmd_beat, k[0]);
      if (dir_rows[k].has_exp && expected_q.size() > 0 &&
          (expected_q[$].remaining_qty !== dir_rows[k].exp_rem ||
           expected_q[$].outcome !== dir_rows[k].exp_oc)) begin
        $display("%0t: table row %0d expected rem %0d oc %0d actual rem %0d oc %0d", $time, k,
                 dir_rows[k].exp_rem, dir_rows[k].exp_oc, expected_q[$].remaining_qty,
                 expected_q[$].outcome);
        n_errors++;
      end
    end

    // fill the book to capacity, then overflow it
    while (expected_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < SLOTS + 3; i++)
      send_cmd(mk_sub(SIDE_BUY, KIND_LIMIT, 10 + (i % 4), 1 + i), 1'b0);
    // one sweep that takes many levels
    send_cmd(mk_sub(SIDE_SELL, KIND_MARKET, 0, 32'hFFFF_FFFF), 1'b0);

    // random part: mostly prices near a mid, cancels of issued ids, some noise
    base = 1000;
    for (int n = 0; n < 340; n++) begin
      gap_mode = (n / 40) % 3;
      mode = $urandom_range(0, 99);
      if (mode < 22 && issued_ids.size() > 0) begin
        pick = $urandom_range(0, issued_ids.size() - 1);
        r = mk_cancel(issued_ids[pick]);
      end else if (mode < 26) begin
        r = mk_cancel({$urandom, $urandom});
      end else if (mode < 30) begin
        r = ReqW'({$urandom, $urandom, $urandom, $urandom, $urandom});
        r.cmd = CMD_SUBMIT;
      end else begin
        r = mk_sub(1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0),
                   base - 8 + $urandom_range(0, 16),
                   ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 60));
      end
      send_cmd(r, gap_mode != 2);
    end

    // drain
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS * 4) @(posedge clk_i);
    $display("covered %0d results: %0d fills, %0d cancels hit, %0d book-full drops",
             n_results, n_fills, n_cancel_hits, n_full);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
